@@ sv/audio_rms_level_meter_macros.svh @@
// ---------------------------------------------------------------------------
// audio_rms_level_meter_macros.svh
// Assertion macros for the RMS level meter.
// ---------------------------------------------------------------------------
`ifndef AUDIO_RMS_LEVEL_METER_MACROS_SVH
`define AUDIO_RMS_LEVEL_METER_MACROS_SVH
`ifndef ASSERT_OFF
// Implication checked every clock, off during reset.
`define ARM_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ARM_ASSERT_NXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ARM_ASSERT_IMP(label, clk, rst, pre, post)
`define ARM_ASSERT_NXT(label, clk, rst, pre, post)
`endif
`endif

@@ sv/arm_pkg.sv @@
// ---------------------------------------------------------------------------
// arm_pkg
// Shared types and constants of the RMS level meter.
// ---------------------------------------------------------------------------
package arm_pkg;

  localparam int unsigned SumW   = 49;
  localparam int unsigned CountW = 17;
  localparam logic [CountW-1:0] MaxSamples = 17'd65536;

  localparam logic [2:0] FmtPcm8  = 3'd0;
  localparam logic [2:0] FmtPcm16 = 3'd1;
  localparam logic [2:0] FmtPcm24 = 3'd2;
  localparam logic [2:0] FmtPcm32 = 3'd3;
  localparam logic [2:0] FmtF32   = 3'd4;
  localparam logic [2:0] FmtF32S  = 3'd5;

  localparam logic [0:0] RegSampleFormat = 1'b0;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // register input sample
    logic accum;     // square and add
    logic div_start; // load divider
    logic div_step;  // one quotient bit
    logic sqrt_start;
    logic sqrt_step;
    logic clear;     // clear accumulators
  } arm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic zero_result; // silent, bad format or empty
  } arm_stat_t;

endpackage

@@ sv/audio_rms_level_meter.sv @@
// ---------------------------------------------------------------------------
// audio_rms_level_meter
// Packet RMS level meter: convert, square, accumulate, divide, square root.
// ---------------------------------------------------------------------------
// Channel   Signals                                   Dir
// input     in_valid/in_ready, sample_word,           in
//           last_sample, packet_silent
// output    out_valid/out_ready, rms_level            out
// config    APB psel/penable/pwrite/paddr/pwdata      in
//
// A sample request is registered, squared and added; the last one of a
// packet then runs a restoring divide (one bit per cycle), a square root (two
// bits per cycle) and the output stage. Reset is synchronous; format resets
// to pcm16. A stalled result holds the next result in the output state.
module audio_rms_level_meter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] sample_word,
  input  logic        last_sample,
  input  logic        packet_silent,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] rms_level,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  arm_pkg::arm_cmd_t  cmd;
  arm_pkg::arm_stat_t stat;
  logic [2:0]  sample_format;
  logic [15:0] root;

  assign pready = 1'b1;
  assign prdata = {29'd0, sample_format};

  always_ff @(posedge clk) begin
    if (rst) sample_format <= arm_pkg::FmtPcm16;
    else if (psel && penable && pwrite && paddr == arm_pkg::RegSampleFormat)
      sample_format <= pwdata[2:0];
  end

  arm_datapath u_dp (
    .clk, .rst, .cmd, .stat, .sample_format, .sample_word, .packet_silent, .root
  );

  arm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .last_sample, .out_valid, .out_ready,
    .cmd, .stat, .root, .rms_level
  );

endmodule

@@ sv/arm_datapath.sv @@
// ---------------------------------------------------------------------------
// arm_datapath
// Sample conversion, square accumulation, serial divide and square root.
// ---------------------------------------------------------------------------
module arm_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  arm_pkg::arm_cmd_t         cmd,
  output arm_pkg::arm_stat_t        stat,
  input  logic [2:0]                sample_format,
  input  logic [31:0]               sample_word,
  input  logic                      packet_silent,
  output logic [15:0]               root
);

  logic [31:0] word_r;
  logic [2:0]  fmt_r;
  logic [32:0] mag;
  logic [32:0] mag_r;
  logic [61:0] prod;
  logic [31:0] sq;
  logic        silent_seen;
  logic        add_pend;
  logic [arm_pkg::SumW-1:0]   sum_use;
  logic [arm_pkg::SumW-1:0]   sum_next;
  logic [arm_pkg::CountW-1:0] cnt_use;
  // divider: restoring, 49 quotient bits
  logic [arm_pkg::SumW-1:0]   quo;
  logic [arm_pkg::SumW-1:0]   quo_next;
  logic [arm_pkg::CountW:0]   rem;
  logic [arm_pkg::CountW:0]   rem_sh;
  logic [arm_pkg::CountW:0]   rem_next;
  // square root: two bits per step
  logic [arm_pkg::SumW:0]     rv;
  logic [arm_pkg::SumW:0]     rr;
  logic [arm_pkg::SumW:0]     rbit;
  logic [arm_pkg::SumW:0]     trial;

  function automatic logic [32:0] fmag(input logic [31:0] w, input logic scaled);
    logic [7:0]  e;
    logic [55:0] m;
    logic signed [9:0] s;
    logic [55:0] t;
    begin
      e = w[30:23];
      m = {32'd0, (e != 8'd0), w[22:0]};
      if (e == 8'd0) e = 8'd1;
      s = $signed({2'b00, e}) - 10'sd119 - (scaled ? 10'sd15 : 10'sd0);
      t = 56'd0;
      if (w[30:23] == 8'hFF || m == 56'd0) fmag = 33'd0;
      else if (s >= 10'sd8) fmag = 33'h080000000;
      else if (s >= 10'sd0) begin
        t = m << s[2:0];
        fmag = (t > 56'h80000000) ? 33'h080000000 : t[32:0];
      end else if (s <= -10'sd32) fmag = 33'd0;
      else begin
        t = m >> (-s);
        fmag = t[32:0];
      end
    end
  endfunction

  always_comb begin
    case (fmt_r)
      arm_pkg::FmtPcm8:
        mag = word_r[7] ? {2'b0, word_r[6:0], 24'd0}
                        : {1'b0, 8'd128 - {1'b0, word_r[6:0]}, 24'd0};
      arm_pkg::FmtPcm16:
        mag = word_r[15] ? {1'b0, 16'd0 - word_r[15:0], 16'd0}
                         : {1'b0, word_r[15:0], 16'd0};
      arm_pkg::FmtPcm24:
        mag = word_r[23] ? {1'b0, 24'd0 - word_r[23:0], 8'd0}
                         : {1'b0, word_r[23:0], 8'd0};
      arm_pkg::FmtPcm32:
        mag = word_r[31] ? {1'b0, 32'd0 - word_r} : {1'b0, word_r};
      arm_pkg::FmtF32:  mag = fmag(word_r, 1'b0);
      arm_pkg::FmtF32S: mag = fmag(word_r, 1'b1);
      default: mag = 33'd0;
    endcase
  end

  // mag <= 2^31: below full scale the square >> 30 fits 32 bits, full scale saturates.
  assign prod = mag_r[30:0] * mag_r[30:0];
  assign sq   = (mag_r[32:31] != 2'd0) ? 32'hFFFFFFFF : prod[61:30];

  // Add stage: runs in the cycle after accum; samples past the limit are dropped.
  always_comb begin
    sum_next = sum_use;
    if (add_pend && cnt_use != arm_pkg::MaxSamples)
      sum_next = sum_use + {{(arm_pkg::SumW-32){1'b0}}, sq};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_r <= sample_word;
      fmt_r  <= sample_format;
    end
    if (cmd.accum) mag_r <= mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_use <= '0; cnt_use <= '0; silent_seen <= 1'b0; add_pend <= 1'b0;
    end else begin
      add_pend <= cmd.accum;
      if (cmd.clear) begin
        sum_use <= '0; cnt_use <= '0; silent_seen <= 1'b0;
      end else begin
        sum_use <= sum_next;
        if (add_pend && cnt_use != arm_pkg::MaxSamples) cnt_use <= cnt_use + 1'b1;
        if (cmd.load && packet_silent) silent_seen <= 1'b1;
      end
    end
  end

  assign stat.zero_result = silent_seen || (fmt_r > arm_pkg::FmtF32S) || (cnt_use == '0);

  assign rem_sh = {rem[arm_pkg::CountW-1:0], quo[arm_pkg::SumW-1]};
  assign trial  = rr + rbit;

  always_comb begin
    if (rem_sh >= {1'b0, cnt_use}) begin
      rem_next = rem_sh - {1'b0, cnt_use};
      quo_next = {quo[arm_pkg::SumW-2:0], 1'b1};
    end else begin
      rem_next = rem_sh;
      quo_next = {quo[arm_pkg::SumW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    // divide starts on the sum that includes the last sample
    if (cmd.div_start) begin
      quo <= sum_next;
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_next;
      quo <= quo_next;
    end
    // root starts on the quotient after its final bit
    if (cmd.sqrt_start) begin
      rv   <= {1'b0, quo_next};
      rr   <= '0;
      rbit <= {2'b01, 48'd0};
    end else if (cmd.sqrt_step) begin
      if (rv >= trial) begin
        rv <= rv - trial;
        rr <= (rr >> 1) + rbit;
      end else begin
        rr <= rr >> 1;
      end
      rbit <= rbit >> 2;
    end
  end

  // Quotient < 2^49, root < 2^24.5; saturate to 16 bits.
  assign root = (rr[arm_pkg::SumW:16] != '0) ? 16'hFFFF : rr[15:0];

endmodule

@@ sv/arm_ctrl.sv @@
// ---------------------------------------------------------------------------
// arm_ctrl
// Sequencer: accept, square, accumulate, divide, square root, output.
// ---------------------------------------------------------------------------
`include "audio_rms_level_meter_macros.svh"
module arm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 last_sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output arm_pkg::arm_cmd_t    cmd,
  input  arm_pkg::arm_stat_t   stat,
  input  logic [15:0]          root,
  output logic [15:0]          rms_level
);

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_ADD, S_DIV, S_SQRT, S_OUT
  } state_t;

  state_t     state;
  logic       last_r;
  logic [5:0] cnt;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load       = in_valid && in_ready;
    cmd.accum      = (state == S_SQ);
    cmd.div_start  = (state == S_ADD) && last_r;
    cmd.div_step   = (state == S_DIV);
    cmd.sqrt_start = (state == S_DIV) && (cnt == 6'd48);
    cmd.sqrt_step  = (state == S_SQRT);
    cmd.clear      = (state == S_OUT) && !out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; cnt <= '0; last_r <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) begin
          last_r <= last_sample;
          state  <= S_SQ;
        end
        S_SQ:  state <= S_ADD;
        S_ADD: begin
          // sum settles this edge; divide next on the last sample
          cnt   <= '0;
          state <= last_r ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == 6'd48) begin
            cnt <= '0; state <= S_SQRT;
          end
        end
        S_SQRT: begin
          cnt <= cnt + 1'b1;
          if (cnt == 6'd24) state <= S_OUT;
        end
        S_OUT: if (!out_valid) begin
          rms_level <= stat.zero_result ? 16'd0 : root;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ARM_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, state == S_IDLE)
  `ARM_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(rms_level))
  `ARM_ASSERT_IMP(a_no_out_mid, clk, rst, state == S_DIV, !cmd.load)

endmodule

@@ test/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the packet RMS level meter. Samples are sent over
// a valid/ready channel while a running model of the meter predicts each
// packet's level. Results are checked in order against that prediction.
// ---------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  // format codes with no package name
  localparam logic [2:0] FmtBad6 = 3'd6;
  localparam logic [2:0] FmtBad7 = 3'd7;
  localparam int DrainCycles = 120;   // covers divide + sqrt + output stage

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] sample_word = '0;
  logic        last_sample = 1'b0;
  logic        packet_silent = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] rms_level;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [0:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  audio_rms_level_meter i_dut (.*);

  always #1 clk = ~clk;

  // ---- level model: format register and packet accumulators ----
  logic [2:0]  fmt_reg = arm_pkg::FmtPcm16;
  logic [63:0] sq_acc = '0;
  logic [16:0] n_acc = '0;
  logic        quiet_acc = 1'b0;
  logic [15:0] level_q[$];     // expected rms levels, oldest first

  int errors = 0;
  int send_idle_pct = 0;       // percent of cycles the sender holds back
  int rcv_stall_pct = 0;       // percent of cycles the receiver stalls
  int hold_cycles = 0;         // long receiver hold-off, counted below

  // float bits -> Q1.31 magnitude, scaled down by 2^extra
  function automatic logic [31:0] float_to_mag(logic [31:0] w, int extra);
    logic [7:0]  e;
    logic [63:0] m;
    int          s;
    e = w[30:23];
    m = {41'd0, w[22:0]};
    if (e == 8'hFF) return 0;             // inf / NaN count as zero
    if (e == 0) e = 8'd1;                 // denormal
    else m[23] = 1'b1;
    if (m == 0) return 0;
    s = int'(e) - 119 - extra;
    if (s >= 8) return 32'h8000_0000;
    if (s >= 0) begin
      m = m << s;
      return (m > 64'h8000_0000) ? 32'h8000_0000 : m[31:0];
    end
    if (-s >= 32) return 0;
    m = m >> (-s);
    return m[31:0];
  endfunction

  function automatic logic [31:0] word_to_mag(logic [31:0] w, logic [2:0] f);
    longint v;
    case (f)
      arm_pkg::FmtPcm8:  v = (longint'(w[7:0]) - 128) * 64'sd16777216;
      arm_pkg::FmtPcm16: v = longint'($signed(w[15:0])) * 65536;
      arm_pkg::FmtPcm24: v = longint'($signed(w[23:0])) * 256;
      arm_pkg::FmtPcm32: v = longint'($signed(w));
      arm_pkg::FmtF32:   return float_to_mag(w, 0);
      arm_pkg::FmtF32S:  return float_to_mag(w, 15);
      default:           return 0;
    endcase
    if (v < 0) v = -v;
    return v[31:0];
  endfunction

  function automatic logic [15:0] int_sqrt(logic [63:0] v);
    logic [15:0] r;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      r[b] = 1'b1;
      if ({48'd0, r} * {48'd0, r} > v) r[b] = 1'b0;
    end
    return r;
  endfunction

  // fold one accepted sample into the model, queue a level at packet end
  task automatic accumulate_sample(logic [31:0] w, logic lst, logic sil);
    logic [63:0] mag;
    logic [63:0] sq;
    logic [63:0] mean;
    logic [15:0] lvl;
    if (sil) quiet_acc = 1'b1;
    if (n_acc < arm_pkg::MaxSamples) begin
      mag = {32'd0, word_to_mag(w, fmt_reg)};
      sq = (mag * mag) >> 30;
      if (sq > 64'hFFFF_FFFF) sq = 64'hFFFF_FFFF;
      sq_acc += sq;
      n_acc++;
    end
    if (lst) begin
      lvl = '0;
      if (!quiet_acc && fmt_reg <= arm_pkg::FmtF32S && n_acc != 0) begin
        mean = sq_acc / n_acc;
        lvl = int_sqrt(mean);
      end
      level_q.push_back(lvl);
      sq_acc = '0;
      n_acc = '0;
      quiet_acc = 1'b0;
    end
  endtask

  // ---- request driver ----
  task automatic send_sample(logic [31:0] w, logic lst, logic sil);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      sample_word <= $urandom;   // garbage while idle
    end
    @(negedge clk);
    in_valid <= 1'b1;
    sample_word <= w;
    last_sample <= lst;
    packet_silent <= sil;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accumulate_sample(w, lst, sil);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (level_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // APB write: setup then access; block must be idle
  task automatic write_format(logic [2:0] f);
    wait_drained();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= arm_pkg::RegSampleFormat;
    pwdata <= {$urandom} & 32'hFFFF_FFF8 | {29'd0, f};  // upper bits ignored
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    fmt_reg = f;
  endtask

  // ---- receiver: random stalls plus optional long hold-off ----
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // ---- result checker ----
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (level_q.size() == 0) begin
        $error("unexpected rms_level result: actual %0d", rms_level);
        errors++;
      end else begin
        if (rms_level !== level_q[0]) begin
          $error("rms_level mismatch: expected %0d, actual %0d", level_q[0], rms_level);
          errors++;
        end
        void'(level_q.pop_front());
      end
    end
  end

  // ---- stimulus helpers ----
  function automatic logic [31:0] pick_word(logic [2:0] f);
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(4))
      0: w = w;
      1: case ($urandom_range(5))
           0: w = 32'h0000_0000;
           1: w = 32'hFFFF_FFFF;
           2: w = 32'h8000_0000;
           3: w = 32'h7FFF_FFFF;
           4: w = 32'h7F80_0000 | ($urandom & 32'h807F_FFFF);   // inf / NaN
           default: w = $urandom & 32'h807F_FFFF;                // denormal
         endcase
      2, 3: begin
        // floats near the interesting exponent range
        w[30:23] = 8'($urandom_range(90, 160));
      end
      default: w = $urandom & 32'h0000_00FF;
    endcase
    if (f == arm_pkg::FmtF32S && $urandom_range(1)) w[30:23] = 8'($urandom_range(120, 145));
    return w;
  endfunction

  task automatic send_packet(logic [2:0] f, int len);
    logic sil;
    sil = ($urandom_range(15) == 0);
    for (int i = 0; i < len; i++)
      send_sample(pick_word(f), i == len - 1, sil && ($urandom_range(3) == 0 || i == len - 1));
  endtask

  // ---- tests ----
  task automatic test_directed();
    logic [2:0] f;
    for (int k = 0; k < 8; k++) begin
      f = 3'(k);
      write_format(f);
      case (f)
        arm_pkg::FmtPcm8: begin
          send_sample(32'h0000_0000, 1'b0, 1'b0);
          send_sample(32'hFFFF_FF80, 1'b0, 1'b0);    // mid code, upper bits set
          send_sample(32'h0000_00FF, 1'b1, 1'b0);
        end
        arm_pkg::FmtPcm16: begin
          send_sample(32'hFFFF_8000, 1'b1, 1'b0);    // full-scale negative alone
          send_sample(32'h0000_7FFF, 1'b0, 1'b0);
          send_sample(32'h1234_0001, 1'b1, 1'b1);    // silent on last only
        end
        arm_pkg::FmtPcm24: begin
          send_sample(32'hAB80_0000, 1'b0, 1'b1);    // silent mid-packet
          send_sample(32'h007F_FFFF, 1'b1, 1'b0);
        end
        arm_pkg::FmtPcm32: begin
          send_sample(32'h8000_0000, 1'b0, 1'b0);
          send_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
        end
        arm_pkg::FmtF32: begin
          send_sample(32'h3F80_0000, 1'b0, 1'b0);    // +1.0 full scale
          send_sample(32'hC000_0000, 1'b0, 1'b0);    // -2.0 saturates
          send_sample(32'h7F80_0000, 1'b0, 1'b0);    // infinity
          send_sample(32'h7FC0_0001, 1'b0, 1'b0);    // NaN
          send_sample(32'h0000_0001, 1'b1, 1'b0);    // smallest denormal
        end
        arm_pkg::FmtF32S: begin
          send_sample(32'h4700_0000, 1'b0, 1'b0);    // 32768.0
          send_sample(32'hC6FF_FE00, 1'b1, 1'b0);
        end
        default: begin
          send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);    // unsupported format
          send_sample(32'h8000_0000, 1'b1, 1'b0);
        end
      endcase
      stop_sending();
    end
  endtask

  // receiver holds off while the sender keeps pushing short packets
  task automatic test_backpressure();
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    write_format(arm_pkg::FmtPcm16);
    @(negedge clk);
    hold_cycles = 600;
    for (int i = 0; i < 12; i++) send_packet(arm_pkg::FmtPcm16, $urandom_range(1, 3));
    stop_sending();
    wait_drained();   // sender waits for every result
  endtask

  task automatic test_random();
    int idle_tbl[4] = '{0, 69, 0, 36};
    int stall_tbl[4] = '{0, 0, 69, 36};
    logic [2:0] fmt_tbl[4] = '{arm_pkg::FmtPcm8, arm_pkg::FmtF32S, FmtBad7, arm_pkg::FmtF32};
    int sent;
    int len;
    for (int ph = 0; ph < 4; ph++) begin
      for (int sub = 0; sub < 2; sub++) begin
        write_format(sub == 0 ? fmt_tbl[ph] : 3'($urandom_range(7)));
        send_idle_pct = idle_tbl[ph];
        rcv_stall_pct = stall_tbl[ph];
        sent = 0;
        while (sent < 62) begin
          len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
          send_packet(fmt_reg, len);
          sent += len;
        end
        stop_sending();
      end
    end
    send_idle_pct = 0;
    rcv_stall_pct = 0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    test_backpressure();
    write_format(FmtBad6);   // last register setting: unsupported code
    send_packet(FmtBad6, 3);
    stop_sending();
    wait_drained();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ audio_rms_level_meter.f @@
+incdir+sv
sv/arm_pkg.sv
sv/arm_datapath.sv
sv/arm_ctrl.sv
sv/audio_rms_level_meter.sv
test/tb_top.sv
